/* src/fixed_vector_dot_cross_quick_mag_unit_assert.svh */
// ----------------------------------------------------------------------------
// fixed_vector_dot_cross_quick_mag_unit_assert.svh
// Assertion macros used by the vector ALU top level.
// ----------------------------------------------------------------------------
`ifndef FIXED_VECTOR_DOT_CROSS_QUICK_MAG_UNIT_ASSERT_SVH
`define FIXED_VECTOR_DOT_CROSS_QUICK_MAG_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, quiet during reset
`define FVDCQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FVDCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/fvdcq_pkg.sv */
// ----------------------------------------------------------------------------
// fvdcq_pkg
// Types, constants and helpers for the 16.16 fixed-point vector ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fvdcq_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned PROD_W     = 2 * DATA_W;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned SAT_MID    = FRAC_W + DATA_W - 1;
    localparam int unsigned N_LANES    = 3;
    localparam int unsigned PIPE_DEPTH = 5;

    typedef logic [1:0]                t_op;
    typedef logic signed [DATA_W-1:0]  t_word;
    typedef logic signed [PROD_W-1:0]  t_prod;

    localparam t_op OP_DOT   = 2'd0;
    localparam t_op OP_CROSS = 2'd1;
    localparam t_op OP_MAG   = 2'd2;
    localparam t_op OP_DIST  = 2'd3;

    localparam t_word SAT_POS = 32'sh7FFF_FFFF;
    localparam t_word SAT_NEG = 32'sh8000_0001;

    typedef struct packed {
        t_op   op;
        t_word a_x;
        t_word a_y;
        t_word a_z;
        t_word b_x;
        t_word b_y;
        t_word b_z;
    } t_in_beat;

    typedef struct packed {
        t_word r_x;
        t_word r_y;
        t_word r_z;
    } t_out_beat;

    typedef struct packed {
        logic ld_mul;
        logic ld_sum;
    } t_lane_ctl;

    typedef struct packed {
        logic ld_c;
        logic ld_d;
        logic ld_e;
        t_op  op_c;
        t_op  op_d;
        t_op  op_e;
    } t_merge_ctl;

    // bits 47:16, clamped when the top bit and bit 47 disagree
    function automatic t_word sat_mid(input t_prod q);
        t_word res;
        if (q[PROD_W-1] != q[SAT_MID]) begin
            res = q[PROD_W-1] ? SAT_NEG : SAT_POS;
        end else begin
            res = t_word'(q[SAT_MID:FRAC_W]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/fvdcq_lane.sv */
// ----------------------------------------------------------------------------
// fvdcq_lane
// One component lane: two signed products and their sum, plus the component
// (difference for distance) and its absolute value for the magnitude ops.
// ----------------------------------------------------------------------------
`default_nettype none

module fvdcq_lane (
    input  logic                  i_clk,
    input  fvdcq_pkg::t_lane_ctl  i_ctl,
    input  fvdcq_pkg::t_op        i_op,
    input  fvdcq_pkg::t_word      i_m0a,
    input  fvdcq_pkg::t_word      i_m0b,
    input  fvdcq_pkg::t_word      i_m1a,
    input  fvdcq_pkg::t_word      i_m1b,
    input  fvdcq_pkg::t_word      i_va,
    input  fvdcq_pkg::t_word      i_vb,
    output fvdcq_pkg::t_prod      o_sum,
    output fvdcq_pkg::t_word      o_abs
);
    import fvdcq_pkg::*;

    t_prod r_p0;
    t_prod r_p1;
    t_word r_d;
    t_prod r_sum;
    t_word r_abs;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            r_p0 <= i_m0a * i_m0b;
            r_p1 <= i_m1a * i_m1b;
            r_d  <= (i_op == OP_DIST) ? t_word'(i_va - i_vb) : i_va;
        end
        if (i_ctl.ld_sum) begin
            r_sum <= r_p0 + r_p1;
            // most negative value wraps back onto itself
            r_abs <= r_d[DATA_W-1] ? t_word'(-r_d) : r_d;
        end
    end

    assign o_sum = r_sum;
    assign o_abs = r_abs;

endmodule

`default_nettype wire

/* src/fvdcq_merge.sv */
// ----------------------------------------------------------------------------
// fvdcq_merge
// Combines the lane results: dot sum and clamp, cross clamp, and the
// sort and shift-add of the quick magnitude. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fvdcq_merge (
    input  logic                   i_clk,
    input  fvdcq_pkg::t_merge_ctl  i_ctl,
    input  fvdcq_pkg::t_prod       i_sum [fvdcq_pkg::N_LANES],
    input  fvdcq_pkg::t_word       i_abs [fvdcq_pkg::N_LANES],
    output fvdcq_pkg::t_out_beat   o_data
);
    import fvdcq_pkg::*;

    t_prod r_c_t;
    t_prod r_c_s2;
    t_word r_c_v [N_LANES];
    t_word r_d_v [N_LANES];
    t_word r_x;
    t_word r_y;
    t_word r_z;

    t_word s_hi;
    t_word s_md;
    t_word s_lo;
    t_prod q_dot;
    t_word bc;

    // three-element sort, signed compare
    always_comb begin
        t_word t;
        t    = '0;
        s_hi = i_abs[0];
        s_md = i_abs[1];
        s_lo = i_abs[2];
        if (s_hi < s_md) begin
            t = s_hi; s_hi = s_md; s_md = t;
        end
        if (s_md < s_lo) begin
            t = s_md; s_md = s_lo; s_lo = t;
            if (s_hi < s_md) begin
                t = s_hi; s_hi = s_md; s_md = t;
            end
        end
    end

    assign q_dot = r_c_t + r_c_s2;
    assign bc    = (r_c_v[1] >>> 2) + (r_c_v[2] >>> 3);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_c) begin
            r_c_t  <= i_sum[0] + i_sum[1];
            r_c_s2 <= i_sum[2];
            if (i_ctl.op_c == OP_CROSS) begin
                for (int k = 0; k < N_LANES; k++) begin
                    r_c_v[k] <= sat_mid(i_sum[k]);
                end
            end else begin
                r_c_v[0] <= s_hi;
                r_c_v[1] <= s_md;
                r_c_v[2] <= s_lo;
            end
        end
        if (i_ctl.ld_d) begin
            case (i_ctl.op_d)
                OP_DOT: begin
                    r_d_v[0] <= sat_mid(q_dot);
                    r_d_v[1] <= '0;
                    r_d_v[2] <= '0;
                end
                OP_CROSS: begin
                    r_d_v <= r_c_v;
                end
                default: begin
                    r_d_v[0] <= r_c_v[0];
                    r_d_v[1] <= bc;
                    r_d_v[2] <= '0;
                end
            endcase
        end
        if (i_ctl.ld_e) begin
            if (i_ctl.op_e inside {OP_MAG, OP_DIST}) begin
                r_x <= r_d_v[0] + r_d_v[1] + (r_d_v[1] >>> 1);
                r_y <= '0;
                r_z <= '0;
            end else begin
                r_x <= r_d_v[0];
                r_y <= r_d_v[1];
                r_z <= r_d_v[2];
            end
        end
    end

    assign o_data = '{r_x: r_x, r_y: r_y, r_z: r_z};

endmodule

`default_nettype wire

/* src/fixed_vector_dot_cross_quick_mag_unit.sv */
// Pipeline: two lane stages and three merge stages from input beat to output valid.
// Throughput: one beat per cycle unless i_ready back-pressure stalls the output stage.
// A stage loads whenever it is empty or the stage after it moves, so bubbles close up
// and new beats are taken while a result waits at the output, until the pipe is full.
// Reset clears only the stage valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
// fixed_vector_dot_cross_quick_mag_unit
// 16.16 fixed-point three-vector ALU: dot, cross, quick magnitude, quick
// distance. Three component lanes feed the merge module.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_vector_dot_cross_quick_mag_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  fvdcq_pkg::t_in_beat    i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output fvdcq_pkg::t_out_beat   o_data
);
    import fvdcq_pkg::*;

`include "fixed_vector_dot_cross_quick_mag_unit_assert.svh"

    logic [PIPE_DEPTH:1]   r_vld;
    logic [PIPE_DEPTH:1]   n_vld;
    logic [PIPE_DEPTH+1:1] rdy;
    t_op                   r_op [PIPE_DEPTH:1];

    t_word      a_v [N_LANES];
    t_word      b_v [N_LANES];
    t_prod      lane_sum [N_LANES];
    t_word      lane_abs [N_LANES];
    t_lane_ctl  lane_ctl;
    t_merge_ctl merge_ctl;
    logic       is_cross;

    always_comb begin
        rdy[PIPE_DEPTH+1] = i_ready;
        for (int k = PIPE_DEPTH; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign n_vld = {r_vld[PIPE_DEPTH-1:1], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= PIPE_DEPTH; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_op[1] <= i_data.op;
        end
        for (int k = 2; k <= PIPE_DEPTH; k++) begin
            if (rdy[k]) begin
                r_op[k] <= r_op[k-1];
            end
        end
    end

    assign o_ready = rdy[1];
    assign o_valid = r_vld[PIPE_DEPTH];

    assign a_v[0] = i_data.a_x;
    assign a_v[1] = i_data.a_y;
    assign a_v[2] = i_data.a_z;
    assign b_v[0] = i_data.b_x;
    assign b_v[1] = i_data.b_y;
    assign b_v[2] = i_data.b_z;
    assign is_cross = (i_data.op == OP_CROSS);

    assign lane_ctl = '{ld_mul: rdy[1], ld_sum: rdy[2]};

    // cross lane k: a[k+1]*b[k+2] - a[k+2]*b[k+1]; dot lane k: a[k]*b[k]
    for (genvar k = 0; k < N_LANES; k++) begin : g_lane
        localparam int K1 = (k + 1) % N_LANES;
        localparam int K2 = (k + 2) % N_LANES;

        fvdcq_lane u_lane (
            .i_clk (i_clk),
            .i_ctl (lane_ctl),
            .i_op  (i_data.op),
            .i_m0a (is_cross ? a_v[K1] : a_v[k]),
            .i_m0b (is_cross ? b_v[K2] : b_v[k]),
            .i_m1a (is_cross ? t_word'(-a_v[K2]) : t_word'(0)),
            .i_m1b (b_v[K1]),
            .i_va  (a_v[k]),
            .i_vb  (b_v[k]),
            .o_sum (lane_sum[k]),
            .o_abs (lane_abs[k])
        );
    end

    assign merge_ctl = '{ld_c: rdy[3], ld_d: rdy[4], ld_e: rdy[5],
                         op_c: r_op[2], op_d: r_op[3], op_e: r_op[4]};

    fvdcq_merge u_merge (
        .i_clk  (i_clk),
        .i_ctl  (merge_ctl),
        .i_sum  (lane_sum),
        .i_abs  (lane_abs),
        .o_data (o_data)
    );

    `FVDCQ_ASSERT_NEXT(a_accept_fills_s1, i_valid && o_ready, r_vld[1], "accepted beat lost at stage 1")
    `FVDCQ_ASSERT_IMPL(a_full_when_blocked, !o_ready, (&r_vld) && !i_ready, "input blocked with a bubble in the pipe")
    `FVDCQ_ASSERT_IMPL(a_scalar_yz_zero, o_valid && r_op[PIPE_DEPTH] != OP_CROSS, o_data.r_y == '0 && o_data.r_z == '0, "scalar op with non-zero y or z")

endmodule

`default_nettype wire

/* dv/fixed_vector_dot_cross_quick_mag_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_vector_dot_cross_quick_mag_unit_test
// Self-checking bench for the 16.16 vector ALU. A directed set covers
// saturation, 64-bit sum wrap, negation of the most negative word and
// quick-magnitude wrap. A random stream with mixed magnitudes follows.
// Both handshakes idle at random, and every result beat is compared with
// a local prediction.
// ----------------------------------------------------------------------------

module fixed_vector_dot_cross_quick_mag_unit_test;

    import fvdcq_pkg::*;

    localparam int    RANDOM_BEATS = 1180;
    localparam int    IDLE_LIMIT   = 1000;
    localparam t_word W_MAX        = 32'sh7FFF_FFFF;
    localparam t_word W_MIN        = 32'sh8000_0000;
    localparam t_word Q_ONE        = 32'sh0001_0000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_beat o_data;

    t_in_beat  vectors_to_send[$];
    t_out_beat expected_results[$];

    int beats_total;
    int beats_in      = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;
    int send_gap      = 0;
    int recv_stall    = 0;
    bit in_burst      = 1'b0;
    bit out_burst     = 1'b0;
    bit in_beat_taken  = 1'b0;
    bit out_beat_taken = 1'b0;

    fixed_vector_dot_cross_quick_mag_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic [63:0] wide_prod(input t_word x, input t_word y);
        longint px;
        longint py;
        px = x;
        py = y;
        return px * py;
    endfunction

    // take bits 47:16, clamp when bit 63 and bit 47 of the sum disagree
    function automatic t_word clamp_q16(input logic [63:0] acc);
        if (acc[63] == acc[47]) begin
            return acc[47:16];
        end
        return acc[63] ? SAT_NEG : SAT_POS;
    endfunction

    function automatic t_word approx_len(input t_word x, input t_word y, input t_word z);
        t_word big;
        t_word mid_v;
        t_word low_v;
        t_word swap;
        t_word frac;
        big   = x[31] ? -x : x;
        mid_v = y[31] ? -y : y;
        low_v = z[31] ? -z : z;
        // signed sort: a wrapped 0x80000000 counts as negative
        if (big < mid_v) begin
            swap = big; big = mid_v; mid_v = swap;
        end
        if (mid_v < low_v) begin
            swap = mid_v; mid_v = low_v; low_v = swap;
            if (big < mid_v) begin
                swap = big; big = mid_v; mid_v = swap;
            end
        end
        frac = (mid_v >>> 2) + (low_v >>> 3);
        return big + frac + (frac >>> 1);
    endfunction

    function automatic t_out_beat vec_alu_result(input t_in_beat b);
        t_out_beat r;
        t_word     nax;
        t_word     nay;
        t_word     naz;
        t_word     dx;
        t_word     dy;
        t_word     dz;
        r   = '0;
        nax = -b.a_x;
        nay = -b.a_y;
        naz = -b.a_z;
        dx  = b.a_x - b.b_x;
        dy  = b.a_y - b.b_y;
        dz  = b.a_z - b.b_z;
        case (b.op)
            OP_DOT: begin
                r.r_x = clamp_q16(wide_prod(b.a_x, b.b_x) + wide_prod(b.a_y, b.b_y)
                                  + wide_prod(b.a_z, b.b_z));
            end
            OP_CROSS: begin
                r.r_x = clamp_q16(wide_prod(b.a_y, b.b_z) + wide_prod(naz, b.b_y));
                r.r_y = clamp_q16(wide_prod(b.a_z, b.b_x) + wide_prod(nax, b.b_z));
                r.r_z = clamp_q16(wide_prod(b.a_x, b.b_y) + wide_prod(nay, b.b_x));
            end
            OP_MAG: begin
                r.r_x = approx_len(b.a_x, b.a_y, b.a_z);
            end
            OP_DIST: begin
                r.r_x = approx_len(dx, dy, dz);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in_beat make_beat(input t_op op,
                                           input t_word ax, input t_word ay, input t_word az,
                                           input t_word bx, input t_word by, input t_word bz);
        t_in_beat b;
        b.op  = op;
        b.a_x = ax;
        b.a_y = ay;
        b.a_z = az;
        b.b_x = bx;
        b.b_y = by;
        b.b_z = bz;
        return b;
    endfunction

    // mix of full-range words, scaled-down words (products near bit 47) and extremes
    function automatic t_word rand_word();
        t_word w;
        int    pick;
        w    = $urandom;
        pick = $urandom_range(0, 6);
        if (pick >= 3 && pick <= 5) begin
            w = w >>> $urandom_range(1, 24);
        end else if (pick == 6) begin
            case ($urandom_range(0, 5))
                0:       w = W_MAX;
                1:       w = W_MIN;
                2:       w = '0;
                3:       w = -1;
                4:       w = SAT_NEG;
                default: w = Q_ONE;
            endcase
        end
        return w;
    endfunction

    task automatic check_word(input string tag, input t_word want, input t_word got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %h, got %h", tag, want, got);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // driver: inputs change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            if (!i_valid || in_beat_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (vectors_to_send.size() != 0) begin
                    i_data  <= vectors_to_send.pop_front();
                    i_valid <= 1'b1;
                    if ($urandom_range(0, 29) == 0) begin
                        in_burst = !in_burst;
                    end
                    send_gap = in_burst ? 0 : $urandom_range(0, 6);
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (out_beat_taken) begin
                if ($urandom_range(0, 29) == 0) begin
                    out_burst = !out_burst;
                end
                recv_stall = out_burst ? 0 : $urandom_range(0, 6);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : observe
        t_out_beat want;
        in_beat_taken  <= i_rst_n && i_valid && o_ready;
        out_beat_taken <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result beat with nothing expected: %h", o_data);
                end
            end else begin
                want = expected_results.pop_front();
                check_word("r_x", want.r_x, o_data.r_x);
                check_word("r_y", want.r_y, o_data.r_y);
                check_word("r_z", want.r_z, o_data.r_z);
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            expected_results.push_back(vec_alu_result(i_data));
            beats_in <= beats_in + 1;
        end
    end

    // no beat on either side for too long: the block has hung
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("fixed_vector_dot_cross_quick_mag_unit_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data  = '0;

        // dot: plain, both saturations, 64-bit wrap, zero, boundary at bit 47
        vectors_to_send.push_back(make_beat(OP_DOT, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        vectors_to_send.push_back(make_beat(OP_DOT, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
        vectors_to_send.push_back(make_beat(OP_DOT, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN));
        vectors_to_send.push_back(make_beat(OP_DOT, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
        vectors_to_send.push_back(make_beat(OP_DOT, '0, '0, '0, '0, '0, '0));
        vectors_to_send.push_back(make_beat(OP_DOT, -1, -1, -1, 1, 1, 1));
        vectors_to_send.push_back(make_beat(OP_DOT, 32'sh0080_0000, 32'sh0080_0000,
                                            32'sh0080_0000, 32'sh0080_0000,
                                            32'sh0080_0000, 32'sh0080_0000));
        vectors_to_send.push_back(make_beat(OP_DOT, 32'sh0080_0000, -32'sh0080_0000,
                                            '0, 32'sh0080_0000, 32'sh0080_0000, W_MAX));
        // cross: unit axes, wrapped negation of the most negative word, saturation
        vectors_to_send.push_back(make_beat(OP_CROSS, Q_ONE, '0, '0, '0, Q_ONE, '0));
        vectors_to_send.push_back(make_beat(OP_CROSS, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
        vectors_to_send.push_back(make_beat(OP_CROSS, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN));
        vectors_to_send.push_back(make_beat(OP_CROSS, W_MIN, Q_ONE, W_MAX, -1, W_MIN, 1));
        vectors_to_send.push_back(make_beat(OP_CROSS, '0, '0, '0, '0, '0, '0));
        // quick magnitude: wrapped absolute value, sum wrap, sorting
        vectors_to_send.push_back(make_beat(OP_MAG, W_MIN, W_MIN, W_MIN, '0, '0, '0));
        vectors_to_send.push_back(make_beat(OP_MAG, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, -1));
        vectors_to_send.push_back(make_beat(OP_MAG, Q_ONE, -2 * Q_ONE, 3 * Q_ONE, '0, '0, '0));
        vectors_to_send.push_back(make_beat(OP_MAG, '0, '0, '0, '0, '0, '0));
        vectors_to_send.push_back(make_beat(OP_MAG, W_MIN, Q_ONE, '0, '0, '0, '0));
        vectors_to_send.push_back(make_beat(OP_MAG, -1, W_MAX, 1, '0, '0, '0));
        // quick distance: wrapped differences
        vectors_to_send.push_back(make_beat(OP_DIST, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN));
        vectors_to_send.push_back(make_beat(OP_DIST, W_MIN, W_MIN, W_MIN, 1, 1, 1));
        vectors_to_send.push_back(make_beat(OP_DIST, Q_ONE, -Q_ONE, W_MAX, Q_ONE, -Q_ONE, W_MAX));
        vectors_to_send.push_back(make_beat(OP_DIST, 5 * Q_ONE, -3 * Q_ONE, 7,
                                            2 * Q_ONE, Q_ONE, -9));
        vectors_to_send.push_back(make_beat(OP_DIST, '0, '0, '0, W_MIN, W_MAX, -1));

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            vectors_to_send.push_back(make_beat(t_op'($urandom_range(0, 3)),
                                                rand_word(), rand_word(), rand_word(),
                                                rand_word(), rand_word(), rand_word()));
        end
        beats_total = vectors_to_send.size();
        recv_stall  = $urandom_range(0, 6);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_in != beats_total || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);
        @(negedge i_clk);

        if (mismatches == 0) begin
            $display("fixed_vector_dot_cross_quick_mag_unit_test: done, clean");
        end else begin
            $display("fixed_vector_dot_cross_quick_mag_unit_test: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/fvdcq_pkg.sv
src/fvdcq_lane.sv
src/fvdcq_merge.sv
src/fixed_vector_dot_cross_quick_mag_unit.sv
dv/fixed_vector_dot_cross_quick_mag_unit_test.sv
